>>> design/msc_pkg.sv
// Shared types, constants and helpers for the matrix syndrome codec.
package msc_pkg;

  localparam int ROW_W    = 16;
  localparam int NUM_ROWS = 8;
  localparam int SYN_W    = 8;
  localparam int POS_W    = 4;
  localparam int CFG_AW   = 5;
  localparam int CFG_DW   = 32;

  localparam logic FUNC_ENCODE = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  typedef logic [ROW_W-1:0]                row_t;
  typedef logic [SYN_W-1:0]                syn_t;
  typedef logic [POS_W-1:0]                pos_t;
  typedef logic [NUM_ROWS-1:0][ROW_W-1:0]  rows_t;
  typedef logic [ROW_W-1:0][POS_W-1:0]     pos_vec_t;
  typedef logic [CFG_DW-1:0]               cfg_data_t;
  typedef logic [CFG_AW-1:0]               cfg_addr_t;

  typedef enum logic [1:0] {
    ST_ENCODED = 2'd0,
    ST_SINGLE  = 2'd1,
    ST_PAIR    = 2'd2,
    ST_NONE    = 2'd3
  } status_t;

  typedef struct packed {
    logic func;
    row_t word;
    syn_t syn;
  } stage_a_t;

  typedef struct packed {
    logic     func;
    row_t     word;
    syn_t     syn;
    row_t     single_hit;
    row_t     pair_hit;
    pos_vec_t pair_b;
    logic     zero_hi;
  } stage_b_t;

  typedef struct packed {
    row_t    out_word;
    syn_t    syndrome;
    status_t status;
    pos_t    first_pos;
    pos_t    second_pos;
  } result_t;

  function automatic syn_t column_of(rows_t rows, int unsigned pos, int unsigned nrows);
    syn_t col;
    col = '0;
    for (int unsigned i = 0; i < NUM_ROWS; i++) begin
      if (i < nrows) begin
        col[i] = rows[i][pos];
      end
    end
    return col;
  endfunction

endpackage

>>> design/msc_if.sv
// Valid/ready channel interfaces for the codec input and result transactions.
interface msc_in_if;
  logic          valid;
  logic          ready;
  logic          func;
  msc_pkg::row_t in_word;

  modport source (output valid, func, in_word, input ready);
  modport sink   (input valid, func, in_word, output ready);
endinterface

interface msc_out_if;
  logic          valid;
  logic          ready;
  msc_pkg::row_t out_word;
  msc_pkg::syn_t syndrome;
  logic [1:0]    status;
  msc_pkg::pos_t first_pos;
  msc_pkg::pos_t second_pos;

  modport source (output valid, out_word, syndrome, status, first_pos, second_pos,
                  input ready);
  modport sink   (input valid, out_word, syndrome, status, first_pos, second_pos,
                  output ready);
endinterface

>>> design/msc_cfg_regs.sv
// APB-style register file holding the parity-check matrix rows.
module msc_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  msc_pkg::cfg_addr_t  paddr,
  input  msc_pkg::cfg_data_t  pwdata,
  output msc_pkg::cfg_data_t  prdata,
  output logic                pready,
  output msc_pkg::rows_t      rows
);

  msc_pkg::rows_t rows_r;
  logic [2:0]     idx;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign rows   = rows_r;
  assign prdata = {{(msc_pkg::CFG_DW - msc_pkg::ROW_W){1'b0}}, rows_r[idx]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= '0;
    end else if (psel && penable && pwrite) begin
      rows_r[idx] <= pwdata[msc_pkg::ROW_W-1:0];
    end
  end

endmodule

>>> design/msc_front.sv
// First stage: input masking, syndrome and the leading check bits of an encode.
module msc_front #(
  parameter int DATA_BITS  = 8,
  parameter int CHECK_ROWS = 8,
  parameter int CODE_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              func,
  input  msc_pkg::row_t     in_word,
  input  msc_pkg::rows_t    rows,
  output logic              out_valid,
  output msc_pkg::stage_a_t out_data,
  input  logic              out_ready
);

  localparam int ENC_A = (CHECK_ROWS + 2) / 3;
  localparam msc_pkg::row_t DMASK = (DATA_BITS >= msc_pkg::ROW_W) ? '1 :
    msc_pkg::row_t'((64'd1 << DATA_BITS) - 64'd1);
  localparam msc_pkg::row_t CMASK = (CODE_BITS >= msc_pkg::ROW_W) ? '1 :
    msc_pkg::row_t'((64'd1 << CODE_BITS) - 64'd1);

  logic              valid_r;
  msc_pkg::stage_a_t data_r;
  msc_pkg::stage_a_t data_nxt;
  msc_pkg::row_t     enc;
  msc_pkg::row_t     dec;
  msc_pkg::syn_t     syn;

  always_comb begin
    enc = in_word & DMASK;
    for (int i = 0; i < ENC_A; i++) begin
      enc = enc | (msc_pkg::row_t'(^(enc & rows[i])) << (DATA_BITS + i));
    end
    dec = in_word & CMASK;
    syn = '0;
    for (int i = 0; i < CHECK_ROWS; i++) begin
      syn[i] = ^(dec & rows[i]);
    end
    data_nxt.func = func;
    data_nxt.word = (func == msc_pkg::FUNC_DECODE) ? dec : enc;
    data_nxt.syn  = (func == msc_pkg::FUNC_DECODE) ? syn : '0;
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> design/msc_search.sv
// Second stage: column and column-pair match search, middle check bits of an encode.
module msc_search #(
  parameter int CHECK_ROWS = 8,
  parameter int DATA_BITS  = 8,
  parameter int CODE_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  msc_pkg::stage_a_t in_data,
  input  msc_pkg::rows_t    rows,
  output logic              out_valid,
  output msc_pkg::stage_b_t out_data,
  input  logic              out_ready
);

  localparam int ENC_A = (CHECK_ROWS + 2) / 3;
  localparam int ENC_B = (2 * ENC_A < CHECK_ROWS) ? 2 * ENC_A : CHECK_ROWS;
  localparam int NPOS  = (CODE_BITS < msc_pkg::ROW_W) ? CODE_BITS : msc_pkg::ROW_W;

  logic                                   valid_r;
  msc_pkg::stage_b_t                      data_r;
  msc_pkg::stage_b_t                      data_nxt;
  msc_pkg::syn_t [msc_pkg::ROW_W-1:0]     cols;
  msc_pkg::row_t                          enc;

  always_comb begin
    for (int j = 0; j < msc_pkg::ROW_W; j++) begin
      cols[j] = msc_pkg::column_of(rows, j, CHECK_ROWS);
    end
    enc = in_data.word;
    for (int i = ENC_A; i < ENC_B; i++) begin
      enc = enc | (msc_pkg::row_t'(^(enc & rows[i])) << (DATA_BITS + i));
    end
    data_nxt.func       = in_data.func;
    data_nxt.word       = (in_data.func == msc_pkg::FUNC_DECODE) ? in_data.word : enc;
    data_nxt.syn        = in_data.syn;
    data_nxt.zero_hi    = (CODE_BITS > msc_pkg::ROW_W) && (in_data.syn == '0);
    data_nxt.single_hit = '0;
    data_nxt.pair_hit   = '0;
    data_nxt.pair_b     = '0;
    for (int a = 0; a < msc_pkg::ROW_W; a++) begin
      data_nxt.single_hit[a] = (a < NPOS) && (cols[a] == in_data.syn);
      // descending so the lowest partner wins
      for (int b = msc_pkg::ROW_W - 1; b >= 0; b--) begin
        if ((a < b) && (b < NPOS) && ((cols[a] ^ cols[b]) == in_data.syn)) begin
          data_nxt.pair_hit[a] = 1'b1;
          data_nxt.pair_b[a]   = msc_pkg::pos_t'(b);
        end
      end
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> design/msc_resolve.sv
// Third stage: match priority, bit flips, final check bits and the result register.
module msc_resolve #(
  parameter int CHECK_ROWS = 8,
  parameter int DATA_BITS  = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  msc_pkg::stage_b_t in_data,
  input  msc_pkg::rows_t    rows,
  output logic              out_valid,
  output msc_pkg::result_t  out_data,
  input  logic              out_ready
);

  localparam int ENC_A = (CHECK_ROWS + 2) / 3;
  localparam int ENC_B = (2 * ENC_A < CHECK_ROWS) ? 2 * ENC_A : CHECK_ROWS;

  logic             valid_r;
  msc_pkg::result_t data_r;
  msc_pkg::result_t data_nxt;
  msc_pkg::row_t    enc;
  msc_pkg::pos_t    single_a;
  msc_pkg::pos_t    pair_a;
  msc_pkg::pos_t    p1;
  msc_pkg::pos_t    p2;
  msc_pkg::row_t    flip;
  msc_pkg::status_t st;

  always_comb begin
    enc = in_data.word;
    for (int i = ENC_B; i < CHECK_ROWS; i++) begin
      enc = enc | (msc_pkg::row_t'(^(enc & rows[i])) << (DATA_BITS + i));
    end
    single_a = '0;
    pair_a   = '0;
    for (int a = msc_pkg::ROW_W - 1; a >= 0; a--) begin
      if (in_data.single_hit[a]) begin
        single_a = msc_pkg::pos_t'(a);
      end
      if (in_data.pair_hit[a]) begin
        pair_a = msc_pkg::pos_t'(a);
      end
    end
    p1   = '0;
    p2   = '0;
    flip = '0;
    priority if (in_data.func == msc_pkg::FUNC_ENCODE) begin
      st = msc_pkg::ST_ENCODED;
    end else if (in_data.single_hit != '0) begin
      st   = msc_pkg::ST_SINGLE;
      p1   = single_a;
      flip = msc_pkg::row_t'(1) << single_a;
    end else if (in_data.zero_hi) begin
      // zero syndrome matched by an unweighted position above the row width
      st = msc_pkg::ST_SINGLE;
    end else if (in_data.pair_hit != '0) begin
      st   = msc_pkg::ST_PAIR;
      p1   = pair_a;
      p2   = in_data.pair_b[pair_a];
      flip = (msc_pkg::row_t'(1) << pair_a) | (msc_pkg::row_t'(1) << in_data.pair_b[pair_a]);
    end else begin
      st = msc_pkg::ST_NONE;
    end
    data_nxt.out_word   = (in_data.func == msc_pkg::FUNC_ENCODE) ? enc : (in_data.word ^ flip);
    data_nxt.syndrome   = in_data.syn;
    data_nxt.status     = st;
    data_nxt.first_pos  = p1;
    data_nxt.second_pos = p2;
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> design/matrix_syndrome_codec.sv
// Throughput: one transaction per cycle while out_ch.ready is high; three register
//   stages (syndrome, match search, priority resolve) each with its own valid bit
//   and local ready.
// Reset (synchronous, active low) empties all stages and clears the check rows;
//   the block accepts input in the first cycle after reset.
module matrix_syndrome_codec #(
  parameter int DATA_BITS  = 8,
  parameter int CHECK_ROWS = 8,
  parameter int CODE_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  msc_in_if.sink             in_ch,
  msc_out_if.source          out_ch,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  msc_pkg::cfg_addr_t cfg_paddr,
  input  msc_pkg::cfg_data_t cfg_pwdata,
  output msc_pkg::cfg_data_t cfg_prdata,
  output logic               cfg_pready
);

  msc_pkg::rows_t    rows;
  logic              a_valid;
  logic              a_ready;
  msc_pkg::stage_a_t a_data;
  logic              b_valid;
  logic              b_ready;
  msc_pkg::stage_b_t b_data;
  msc_pkg::result_t  res;

  msc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .rows    (rows)
  );

  msc_front #(
    .DATA_BITS  (DATA_BITS),
    .CHECK_ROWS (CHECK_ROWS),
    .CODE_BITS  (CODE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .func      (in_ch.func),
    .in_word   (in_ch.in_word),
    .rows      (rows),
    .out_valid (a_valid),
    .out_data  (a_data),
    .out_ready (a_ready)
  );

  msc_search #(
    .CHECK_ROWS (CHECK_ROWS),
    .DATA_BITS  (DATA_BITS),
    .CODE_BITS  (CODE_BITS)
  ) u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (a_valid),
    .in_ready  (a_ready),
    .in_data   (a_data),
    .rows      (rows),
    .out_valid (b_valid),
    .out_data  (b_data),
    .out_ready (b_ready)
  );

  msc_resolve #(
    .CHECK_ROWS (CHECK_ROWS),
    .DATA_BITS  (DATA_BITS)
  ) u_resolve (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (b_valid),
    .in_ready  (b_ready),
    .in_data   (b_data),
    .rows      (rows),
    .out_valid (out_ch.valid),
    .out_data  (res),
    .out_ready (out_ch.ready)
  );

  assign out_ch.out_word   = res.out_word;
  assign out_ch.syndrome   = res.syndrome;
  assign out_ch.status     = res.status;
  assign out_ch.first_pos  = res.first_pos;
  assign out_ch.second_pos = res.second_pos;

`ifndef SYNTH
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("input stalled while result side ready");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == msc_pkg::ST_PAIR) |->
      (out_ch.first_pos < out_ch.second_pos))
    else $error("pair positions out of order");
`endif

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the matrix syndrome codec: directed and random encode/decode traffic.
module tb_top;

  localparam int DATA_W      = 8;
  localparam int CODE_W      = 16;
  localparam int PIPE_DEPTH  = 3;
  localparam int HOLD_CYCLES = 200;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;
  typedef msc_pkg::row_t row_set_t [msc_pkg::NUM_ROWS];
  typedef msc_pkg::syn_t col_set_t [CODE_W];

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  msc_pkg::cfg_addr_t cfg_paddr;
  msc_pkg::cfg_data_t cfg_pwdata;
  msc_pkg::cfg_data_t cfg_prdata;
  logic               cfg_pready;

  msc_in_if  in_ch ();
  msc_out_if out_ch ();

  matrix_syndrome_codec i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  msc_pkg::row_t    check_row [msc_pkg::NUM_ROWS];
  msc_pkg::result_t expected_results [$];
  int               mismatch_count = 0;
  bit               gaps_on = 1'b0;
  int               gap_max = 4;
  int               burst_left = 0;
  rx_mode_t         rx_mode = RX_ALWAYS;
  int               hold_request = 0;
  int               hold_left = 0;
  logic [15:0]      rx_pattern = 16'hA5A5;
  int               rx_pattern_age = 0;

  function automatic msc_pkg::syn_t column_at(int unsigned pos);
    msc_pkg::syn_t col;
    for (int i = 0; i < msc_pkg::NUM_ROWS; i++) begin
      col[i] = check_row[i][pos];
    end
    return col;
  endfunction

  function automatic msc_pkg::result_t codec_predict(logic func, msc_pkg::row_t word);
    msc_pkg::result_t r;
    msc_pkg::row_t    w;
    msc_pkg::row_t    mask;
    msc_pkg::syn_t    syn;
    int               len;
    r = '0;
    if (func == msc_pkg::FUNC_ENCODE) begin
      w   = word & msc_pkg::row_t'((1 << DATA_W) - 1);
      len = DATA_W;
      for (int i = 0; i < msc_pkg::NUM_ROWS; i++) begin
        mask   = msc_pkg::row_t'((1 << len) - 1);
        w[len] = ^(w & check_row[i] & mask);
        len++;
      end
      r.out_word = w;
      r.status   = msc_pkg::ST_ENCODED;
    end else begin
      w = word;
      for (int i = 0; i < msc_pkg::NUM_ROWS; i++) begin
        syn[i] = ^(word & check_row[i]);
      end
      r.syndrome = syn;
      r.status   = msc_pkg::ST_NONE;
      for (int a = 0; a < CODE_W && r.status == msc_pkg::ST_NONE; a++) begin
        if (column_at(a) == syn) begin
          w[a]        = ~w[a];
          r.status    = msc_pkg::ST_SINGLE;
          r.first_pos = msc_pkg::pos_t'(a);
        end
      end
      for (int a = 0; a < CODE_W && r.status == msc_pkg::ST_NONE; a++) begin
        for (int b = a + 1; b < CODE_W && r.status == msc_pkg::ST_NONE; b++) begin
          if ((column_at(a) ^ column_at(b)) == syn) begin
            w[a]         = ~w[a];
            w[b]         = ~w[b];
            r.status     = msc_pkg::ST_PAIR;
            r.first_pos  = msc_pkg::pos_t'(a);
            r.second_pos = msc_pkg::pos_t'(b);
          end
        end
      end
      r.out_word = w;
    end
    return r;
  endfunction

  function automatic msc_pkg::row_t flip_random(msc_pkg::row_t w, int n);
    for (int k = 0; k < n; k++) begin
      w[$urandom_range(0, CODE_W - 1)] ^= 1'b1;
    end
    return w;
  endfunction

  function automatic msc_pkg::row_t codeword_of(msc_pkg::row_t data);
    msc_pkg::result_t r;
    r = codec_predict(msc_pkg::FUNC_ENCODE, data);
    return r.out_word;
  endfunction

  task automatic send_item(logic func, msc_pkg::row_t word);
    if (gaps_on && burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    in_ch.valid   <= 1'b1;
    in_ch.func    <= func;
    in_ch.in_word <= word;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    expected_results = {expected_results, codec_predict(func, word)};
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic cfg_write(int idx, msc_pkg::row_t value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= msc_pkg::cfg_addr_t'(idx * 4);
    cfg_pwdata  <= msc_pkg::cfg_data_t'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    check_row[idx] = value;
  endtask

  task automatic read_rows();
    for (int i = 0; i < msc_pkg::NUM_ROWS; i++) begin
      cfg_psel    <= 1'b1;
      cfg_penable <= 1'b0;
      cfg_pwrite  <= 1'b0;
      cfg_paddr   <= msc_pkg::cfg_addr_t'(i * 4);
      @(posedge clk);
      cfg_penable <= 1'b1;
      do @(posedge clk); while (cfg_pready !== 1'b1);
      if (cfg_prdata[msc_pkg::ROW_W-1:0] !== check_row[i]) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("row %0d read back: expected %h, got %h", i, check_row[i],
                   cfg_prdata[msc_pkg::ROW_W-1:0]);
      end
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic program_rows(row_set_t rs);
    for (int i = 0; i < msc_pkg::NUM_ROWS; i++) begin
      cfg_write(i, rs[i]);
    end
    read_rows();
  endtask

  task automatic program_columns(col_set_t cols);
    row_set_t rs;
    for (int i = 0; i < msc_pkg::NUM_ROWS; i++) begin
      for (int j = 0; j < CODE_W; j++) begin
        rs[i][j] = cols[j][i];
      end
    end
    program_rows(rs);
  endtask

  // zero matrix after reset: every column matches a zero syndrome
  task automatic test_zero_matrix();
    read_rows();
    send_item(msc_pkg::FUNC_DECODE, 16'h0000);
    send_item(msc_pkg::FUNC_DECODE, 16'hFFFF);
    send_item(msc_pkg::FUNC_ENCODE, 16'hFFFF);
    wait_drained();
  endtask

  task automatic test_distinct_columns();
    col_set_t      cols;
    msc_pkg::row_t cw;
    cols = '{8'h03, 8'h05, 8'h06, 8'h09, 8'h0A, 8'h0C, 8'h11, 8'h12,
             8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80};
    program_columns(cols);
    cw = codeword_of(16'h00A5);
    send_item(msc_pkg::FUNC_ENCODE, 16'h0000);
    send_item(msc_pkg::FUNC_ENCODE, 16'hFFFF);
    send_item(msc_pkg::FUNC_DECODE, cw);
    send_item(msc_pkg::FUNC_DECODE, cw ^ 16'h0001);
    send_item(msc_pkg::FUNC_DECODE, cw ^ 16'h8000);
    send_item(msc_pkg::FUNC_DECODE, cw ^ 16'h0101);
    send_item(msc_pkg::FUNC_DECODE, 16'hFFFF);
    wait_drained();
  endtask

  // zero column, then two equal columns without a zero one
  task automatic test_degenerate_columns();
    col_set_t cols;
    cols = '{8'h03, 8'h05, 8'h06, 8'h00, 8'h0A, 8'h0A, 8'h11, 8'h12,
             8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80};
    program_columns(cols);
    send_item(msc_pkg::FUNC_ENCODE, 16'h003C);
    send_item(msc_pkg::FUNC_DECODE, codeword_of(16'h003C));
    wait_drained();
    cols = '{8'h03, 8'h05, 8'h06, 8'h09, 8'h0A, 8'h0C, 8'h06, 8'h12,
             8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80};
    program_columns(cols);
    send_item(msc_pkg::FUNC_ENCODE, 16'h00C3);
    send_item(msc_pkg::FUNC_DECODE, codeword_of(16'h00C3));
    wait_drained();
  endtask

  task automatic test_all_ones();
    row_set_t rs;
    for (int i = 0; i < msc_pkg::NUM_ROWS; i++) rs[i] = 16'hFFFF;
    program_rows(rs);
    send_item(msc_pkg::FUNC_DECODE, 16'h0001);
    send_item(msc_pkg::FUNC_DECODE, 16'h0003);
    send_item(msc_pkg::FUNC_ENCODE, 16'h00FF);
    send_item(msc_pkg::FUNC_ENCODE, 16'h0000);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    row_set_t      rs;
    msc_pkg::row_t data;
    int            n;
    for (int ph = 0; ph < 7; ph++) begin
      wait_drained();
      gaps_on = (ph % 2) != 0;
      gap_max = (ph < 4) ? 4 : 9;
      rx_mode = rx_mode_t'(ph % 3);
      for (int i = 0; i < msc_pkg::NUM_ROWS; i++) begin
        case (ph % 4)
          0: rs[i] = msc_pkg::row_t'(($urandom & ((1 << (DATA_W + i)) - 1)) |
                                     (1 << (DATA_W + i)));
          1: rs[i] = msc_pkg::row_t'($urandom);
          2: rs[i] = msc_pkg::row_t'($urandom & $urandom & $urandom);
          default: begin
            case ($urandom_range(0, 2))
              0: rs[i] = 16'h0000;
              1: rs[i] = 16'hFFFF;
              default: rs[i] = msc_pkg::row_t'($urandom);
            endcase
          end
        endcase
      end
      program_rows(rs);
      n = 0;
      while (n < 240) begin
        if ($urandom_range(0, 9) < 7) begin
          data = msc_pkg::row_t'($urandom);
          send_item(msc_pkg::FUNC_ENCODE, data);
          send_item(msc_pkg::FUNC_DECODE,
                    flip_random(codeword_of(data), $urandom_range(0, 2)));
          n += 2;
        end else if ($urandom_range(0, 1) == 0) begin
          send_item(msc_pkg::FUNC_DECODE,
                    flip_random(codeword_of(msc_pkg::row_t'($urandom)),
                                $urandom_range(3, 5)));
          n++;
        end else begin
          send_item(1'($urandom_range(0, 1)), msc_pkg::row_t'($urandom));
          n++;
        end
      end
    end
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering, so the pipeline backs up
  task automatic test_backpressure();
    gaps_on = 1'b0;
    rx_mode = RX_RANDOM;
    for (int r = 0; r < 3; r++) begin
      hold_request = HOLD_CYCLES;
      repeat (60) send_item(1'($urandom_range(0, 1)), msc_pkg::row_t'($urandom));
    end
    wait_drained();
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (rx_pattern_age == 0) begin
        rx_pattern     = 16'($urandom);
        rx_pattern_age = 48;
      end else begin
        rx_pattern     = {rx_pattern[0], rx_pattern[15:1]};
        rx_pattern_age--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: out_ch.ready <= 1'b1;
          RX_RANDOM: out_ch.ready <= ($urandom_range(0, 3) != 0);
          default:   out_ch.ready <= rx_pattern[0];
        endcase
      end
    end
  end

  always @(posedge clk) begin
    msc_pkg::result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected transaction: word=%h syn=%h st=%0d", out_ch.out_word,
                   out_ch.syndrome, out_ch.status);
      end else begin
        want = expected_results.pop_front();
        if (out_ch.out_word !== want.out_word || out_ch.syndrome !== want.syndrome ||
            out_ch.status !== 2'(want.status) || out_ch.first_pos !== want.first_pos ||
            out_ch.second_pos !== want.second_pos) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected word=%h syn=%h st=%0d p1=%0d p2=%0d",
                     want.out_word, want.syndrome, want.status, want.first_pos,
                     want.second_pos);
            $display("          got      word=%h syn=%h st=%0d p1=%0d p2=%0d",
                     out_ch.out_word, out_ch.syndrome, out_ch.status,
                     out_ch.first_pos, out_ch.second_pos);
          end
        end
      end
    end
  end

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.func    = msc_pkg::FUNC_ENCODE;
    in_ch.in_word = '0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    rst_n         = 1'b0;
    for (int i = 0; i < msc_pkg::NUM_ROWS; i++) check_row[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_zero_matrix();
    test_distinct_columns();
    test_degenerate_columns();
    test_all_ones();
    test_random_traffic();
    test_backpressure();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("** matrix_syndrome_codec: PASSED **");
    end else begin
      $display("** matrix_syndrome_codec: FAILED **");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("** matrix_syndrome_codec: FAILED **");
    $finish;
  end

endmodule
